// ===== sv/binary_min_heap_queue_top_defines.svh =====
// Assertion macros used by the heap queue top module.
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define BMHQ_ASSERT_CLK(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// Concurrent assertion on the module's clk and rst_n.
`define BMHQ_ASSERT(lbl, prop, msg) `BMHQ_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

// ===== sv/bmhq_pkg.sv =====
`timescale 1ns / 1ps

package bmhq_pkg;

    localparam int unsigned CAPACITY_DEF     = 1024;
    localparam int unsigned KEY_BITS_DEF     = 16;
    localparam int unsigned PAYLOAD_BITS_DEF = 16;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_UP   = 6'b000010,
        ST_LAST = 6'b000100,
        ST_DOWN = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_RES  = 6'b100000
    } state_t;

endpackage

// ===== sv/binary_min_heap_queue_top.sv =====
// Channel   Direction  Handshake          Request fields
// in        sink       in_valid/in_stall  op, key, payload
// out       source     out_valid/out_stall popped_key, popped_payload, top_key,
//                                         top_payload, entry_count, status
//
// Each heap level takes one registered read of the heap memory, a key compare and
// one write back. One request is in the heap logic at a time.
// Reset clears the state, the fill count and the output valid flag; the heap
// memory needs no clearing pass.
// A finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`include "binary_min_heap_queue_top_defines.svh"

module binary_min_heap_queue_top
    import bmhq_pkg::*;
#(
    parameter int unsigned CAPACITY     = CAPACITY_DEF,
    parameter int unsigned KEY_BITS     = KEY_BITS_DEF,
    parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [KEY_BITS-1:0]               key,
    input  logic [PAYLOAD_BITS-1:0]           payload,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [KEY_BITS-1:0]               popped_key,
    output logic [PAYLOAD_BITS-1:0]           popped_payload,
    output logic [KEY_BITS-1:0]               top_key,
    output logic [PAYLOAD_BITS-1:0]           top_payload,
    output logic [$clog2(CAPACITY+1)-1:0]     entry_count,
    output logic [1:0]                        status
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned PW = CW + 1;
    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned EW = KEY_BITS + PAYLOAD_BITS;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [PW-1:0]           pos_reg, pos_next;
    logic [PW-1:0]           ch_reg, ch_next;
    logic [KEY_BITS-1:0]     ent_key_reg, ent_key_next;
    logic [PAYLOAD_BITS-1:0] ent_pay_reg, ent_pay_next;
    logic [KEY_BITS-1:0]     pop_key_reg, pop_key_next;
    logic [PAYLOAD_BITS-1:0] pop_pay_reg, pop_pay_next;
    logic [1:0]              status_reg, status_next;
    logic [KEY_BITS-1:0]     root_key_reg;
    logic [PAYLOAD_BITS-1:0] root_pay_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [KEY_BITS-1:0]     out_pop_key_reg;
    logic [PAYLOAD_BITS-1:0] out_pop_pay_reg;
    logic [KEY_BITS-1:0]     out_top_key_reg;
    logic [PAYLOAD_BITS-1:0] out_top_pay_reg;
    logic [CW-1:0]           out_count_reg;
    logic [1:0]              out_status_reg;

    logic                    in_accept;
    logic                    load_out;
    logic                    ram_we;
    logic                    ram_re;
    logic [PW-1:0]           wr_pos;
    logic [PW-1:0]           rd_pos_a;
    logic [PW-1:0]           rd_pos_b;
    logic [PW-1:0]           wr_off;
    logic [PW-1:0]           rd_off_a;
    logic [PW-1:0]           rd_off_b;
    logic [KEY_BITS-1:0]     wr_key;
    logic [PAYLOAD_BITS-1:0] wr_pay;
    logic [EW-1:0]           rdata_a;
    logic [EW-1:0]           rdata_b;
    logic [KEY_BITS-1:0]     rd_key_a;
    logic [KEY_BITS-1:0]     rd_key_b;
    logic [PAYLOAD_BITS-1:0] rd_pay_a;
    logic [PAYLOAD_BITS-1:0] rd_pay_b;
    logic [PW-1:0]           count_ext;
    logic [PW-1:0]           push_pos;
    logic [PW-1:0]           par_pos;
    logic                    take_b;
    logic [KEY_BITS-1:0]     sel_key;
    logic [PAYLOAD_BITS-1:0] sel_pay;
    logic [PW-1:0]           sel_pos;
    logic [PW-1:0]           sel_child;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign load_out  = (state_reg == ST_RES) && (!out_valid_reg || !out_stall);

    assign rd_key_a = rdata_a[EW-1:PAYLOAD_BITS];
    assign rd_pay_a = rdata_a[PAYLOAD_BITS-1:0];
    assign rd_key_b = rdata_b[EW-1:PAYLOAD_BITS];
    assign rd_pay_b = rdata_b[PAYLOAD_BITS-1:0];

    assign count_ext = PW'(count_reg);
    assign push_pos  = count_ext + PW'(1);
    assign par_pos   = pos_reg >> 1;
    assign take_b    = (ch_reg < count_ext) && (rd_key_a > rd_key_b);
    assign sel_key   = take_b ? rd_key_b : rd_key_a;
    assign sel_pay   = take_b ? rd_pay_b : rd_pay_a;
    assign sel_pos   = take_b ? (ch_reg + PW'(1)) : ch_reg;
    assign sel_child = sel_pos << 1;

    assign wr_off   = wr_pos - PW'(1);
    assign rd_off_a = rd_pos_a - PW'(1);
    assign rd_off_b = rd_pos_b - PW'(1);

    bmhq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (wr_off[AW-1:0]),
        .wdata   ({wr_key, wr_pay}),
        .re      (ram_re),
        .raddr_a (rd_off_a[AW-1:0]),
        .raddr_b (rd_off_b[AW-1:0]),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        ch_next        = ch_reg;
        ent_key_next   = ent_key_reg;
        ent_pay_next   = ent_pay_reg;
        pop_key_next   = pop_key_reg;
        pop_pay_next   = pop_pay_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        wr_pos         = pos_reg;
        wr_key         = ent_key_reg;
        wr_pay         = ent_pay_reg;
        rd_pos_a       = par_pos >> 1;
        rd_pos_b       = rd_pos_a;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    pop_key_next = '0;
                    pop_pay_next = '0;
                    status_next  = STATUS_OK;
                    if (op == OP_PUSH)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            status_next = STATUS_FULL;
                            state_next  = ST_RES;
                        end
                        else
                        begin
                            count_next   = count_reg + CW'(1);
                            pos_next     = push_pos;
                            ent_key_next = key;
                            ent_pay_next = payload;
                            if (count_reg == '0)
                            begin
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                rd_pos_a   = push_pos >> 1;
                                rd_pos_b   = push_pos >> 1;
                                state_next = ST_UP;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                            state_next  = ST_RES;
                        end
                        else
                        begin
                            pop_key_next = root_key_reg;
                            pop_pay_next = root_pay_reg;
                            count_next   = count_reg - CW'(1);
                            ram_re       = 1'b1;
                            rd_pos_a     = count_ext;
                            rd_pos_b     = count_ext;
                            if (count_reg == CW'(1))
                            begin
                                state_next = ST_RES;
                            end
                            else
                            begin
                                state_next = ST_LAST;
                            end
                        end
                    end
                end
            end

            ST_UP:
            begin
                if (ent_key_reg < rd_key_a)
                begin
                    ram_we   = 1'b1;
                    wr_key   = rd_key_a;
                    wr_pay   = rd_pay_a;
                    pos_next = par_pos;
                    if (par_pos == PW'(1))
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        ram_re = 1'b1;
                    end
                end
                else
                begin
                    ram_we     = 1'b1;
                    state_next = ST_RES;
                end
            end

            ST_LAST:
            begin
                ent_key_next = rd_key_a;
                ent_pay_next = rd_pay_a;
                pos_next     = PW'(1);
                ch_next      = PW'(2);
                if (count_ext < PW'(2))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    ram_re     = 1'b1;
                    rd_pos_a   = PW'(2);
                    rd_pos_b   = PW'(3);
                    state_next = ST_DOWN;
                end
            end

            ST_DOWN:
            begin
                ram_we = 1'b1;
                if (sel_key > ent_key_reg)
                begin
                    state_next = ST_RES;
                end
                else
                begin
                    wr_key   = sel_key;
                    wr_pay   = sel_pay;
                    pos_next = sel_pos;
                    ch_next  = sel_child;
                    if (sel_child <= count_ext)
                    begin
                        ram_re   = 1'b1;
                        rd_pos_a = sel_child;
                        rd_pos_b = sel_child + PW'(1);
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end

            ST_FIN:
            begin
                ram_we     = 1'b1;
                state_next = ST_RES;
            end

            ST_RES:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        ch_reg      <= ch_next;
        ent_key_reg <= ent_key_next;
        ent_pay_reg <= ent_pay_next;
        pop_key_reg <= pop_key_next;
        pop_pay_reg <= pop_pay_next;
        status_reg  <= status_next;
        if (ram_we && (wr_pos == PW'(1)))
        begin
            root_key_reg <= wr_key;
            root_pay_reg <= wr_pay;
        end
        if (load_out)
        begin
            out_pop_key_reg <= pop_key_reg;
            out_pop_pay_reg <= pop_pay_reg;
            out_top_key_reg <= (count_reg != '0) ? root_key_reg : '0;
            out_top_pay_reg <= (count_reg != '0) ? root_pay_reg : '0;
            out_count_reg   <= count_reg;
            out_status_reg  <= status_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign popped_key     = out_pop_key_reg;
    assign popped_payload = out_pop_pay_reg;
    assign top_key        = out_top_key_reg;
    assign top_payload    = out_top_pay_reg;
    assign entry_count    = out_count_reg;
    assign status         = out_status_reg;

    `BMHQ_ASSERT(a_count_bound, count_reg <= CW'(CAPACITY),
        "Fill count exceeds capacity.")
    `BMHQ_ASSERT(a_rw_disjoint,
        (ram_we && ram_re) |-> (wr_pos != rd_pos_a && wr_pos != rd_pos_b),
        "Heap read and write hit the same entry.")
    `BMHQ_ASSERT(a_full_status,
        (load_out && status_reg == STATUS_FULL) |-> count_reg == CW'(CAPACITY),
        "Full status with a heap that is not full.")
    `BMHQ_ASSERT(a_empty_status,
        (load_out && status_reg == STATUS_EMPTY) |-> count_reg == '0,
        "Empty status with a heap that holds entries.")
    `BMHQ_ASSERT(a_up_not_root, (state_reg == ST_UP) |-> pos_reg > PW'(1),
        "Sift-up step started at the root.")

endmodule

// ===== sv/bmhq_ram.sv =====
`timescale 1ns / 1ps

module bmhq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule
